// ===== design/sha1_message_digest_macros.svh =====
// Assertion macros for the SHA-1 digest block.
`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SHA1_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== design/sha1_pkg.sv =====
// Package: SHA-1 constants and round helpers.
package sha1_pkg;
    localparam int unsigned BufDepth = 64;
    localparam int unsigned PadLimit = 56;
    localparam int unsigned Rounds = 80;
    localparam int unsigned ChainWords = 5;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    function automatic logic [31:0] init_chain(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0: v = 32'h67452301;
            3'd1: v = 32'hefcdab89;
            3'd2: v = 32'h98badcfe;
            3'd3: v = 32'h10325476;
            default: v = 32'hc3d2e1f0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_fk(input logic [6:0] r, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        logic [31:0] k;
        if (r < 7'd20) begin
            f = (b & c) | (~b & d);
            k = 32'h5a827999;
        end else if (r < 7'd40) begin
            f = b ^ c ^ d;
            k = 32'h6ed9eba1;
        end else if (r < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
            k = 32'h8f1bbcdc;
        end else begin
            f = b ^ c ^ d;
            k = 32'hca62c1d6;
        end
        return f + k;
    endfunction
endpackage

// ===== design/sha1_message_digest.sv =====
// SHA-1 digest: byte buffer memory, 80-round compression, digest output.
// An absorb beat writes one byte; the 64th byte of a block starts a buffer
// load, 80 rounds (one per cycle) and an update of the chain words.
// Finish pads one byte per cycle to the block end, runs one or two
// compressions, then emits five words. No byte is taken while a block is
// loaded or compressed or the digest is emitted; rst_n low loads the chain.
module sha1_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
`include "sha1_message_digest_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LOAD, S_ROUND, S_UPDATE, S_EMIT
    } state_t;

    state_t      state_reg;
    logic [7:0]  buf_mem [sha1_pkg::BufDepth];
    logic [7:0]  rd_data_reg;
    logic [5:0]  fill_reg;
    logic [60:0] msg_reg;
    logic [63:0] bits_reg;
    logic        finishing_reg;
    logic        pad_len_reg;
    logic [31:0] h_reg [sha1_pkg::ChainWords];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] w_reg [16];
    logic [6:0]  cnt_reg;
    logic [2:0]  widx_reg;
    logic [31:0] word_acc_reg;

    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [7:0]  wr_data;
    logic [5:0]  rd_addr;
    logic [7:0]  pad_byte;
    logic [31:0] wt;
    logic [31:0] sched;
    logic [31:0] t_sum;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_EMIT);
    assign digest_word = h_reg[widx_reg];
    assign word_index  = widx_reg;
    assign last_word   = (widx_reg == 3'd4);

    always_comb
    begin
        if (fill_reg == 6'd56 && pad_len_reg) begin
            pad_byte = bits_reg[63:56];
        end else if (fill_reg > 6'd56 && pad_len_reg) begin
            pad_byte = bits_reg[63:56];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // byte write path
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = fill_reg;
        wr_data = data_byte;
        if (state_reg == S_IDLE && in_valid && operation == sha1_pkg::OP_ABSORB) begin
            wr_en = 1'b1;
        end else if (state_reg == S_IDLE && in_valid) begin
            wr_en   = 1'b1;
            wr_data = 8'h80;
        end else if (state_reg == S_PAD) begin
            wr_en   = 1'b1;
            wr_data = pad_byte;
        end
    end

    assign rd_addr = cnt_reg[5:0];

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            buf_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= buf_mem[rd_addr];
    end

    assign sched = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign wt = (cnt_reg < 7'd16) ? w_reg[0] : {sched[30:0], sched[31]};
    assign t_sum = {a_reg[26:0], a_reg[31:27]} + e_reg + wt
                 + sha1_pkg::round_fk(cnt_reg, b_reg, c_reg, d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            msg_reg       <= '0;
            bits_reg      <= '0;
            finishing_reg <= 1'b0;
            pad_len_reg   <= 1'b0;
            cnt_reg       <= '0;
            widx_reg      <= '0;
            word_acc_reg  <= '0;
            for (int i = 0; i < 5; i++) begin
                h_reg[i] <= sha1_pkg::init_chain(3'(i));
            end
        end else begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid) begin
                        fill_reg <= fill_reg + 6'd1;
                        if (operation == sha1_pkg::OP_ABSORB) begin
                            msg_reg <= msg_reg + 61'd1;
                            if (fill_reg == 6'd63) begin
                                finishing_reg <= 1'b0;
                                cnt_reg       <= '0;
                                state_reg     <= S_LOAD;
                            end
                        end else begin
                            bits_reg      <= {msg_reg, 3'b000};
                            finishing_reg <= 1'b1;
                            pad_len_reg   <= (fill_reg < 6'd56);
                            if (fill_reg == 6'd63) begin
                                cnt_reg   <= '0;
                                state_reg <= S_LOAD;
                            end else begin
                                state_reg <= S_PAD;
                            end
                        end
                    end
                end
                S_PAD:
                begin
                    fill_reg <= fill_reg + 6'd1;
                    if (pad_len_reg && fill_reg >= 6'd56) begin
                        bits_reg <= {bits_reg[55:0], 8'h00};
                    end
                    if (fill_reg == 6'd63) begin
                        cnt_reg   <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    // registered read: byte i arrives at count i+1
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg != 7'd0) begin
                        word_acc_reg <= {word_acc_reg[23:0], rd_data_reg};
                        if (cnt_reg[1:0] == 2'd0) begin
                            for (int i = 0; i < 15; i++) begin
                                w_reg[i] <= w_reg[i + 1];
                            end
                            w_reg[15] <= {word_acc_reg[23:0], rd_data_reg};
                        end
                    end
                    if (cnt_reg == 7'd64) begin
                        cnt_reg <= '0;
                        a_reg   <= h_reg[0];
                        b_reg   <= h_reg[1];
                        c_reg   <= h_reg[2];
                        d_reg   <= h_reg[3];
                        e_reg   <= h_reg[4];
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    for (int i = 0; i < 15; i++) begin
                        w_reg[i] <= w_reg[i + 1];
                    end
                    w_reg[15] <= wt;
                    a_reg <= t_sum;
                    b_reg <= a_reg;
                    c_reg <= {b_reg[1:0], b_reg[31:2]};
                    d_reg <= c_reg;
                    e_reg <= d_reg;
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'(sha1_pkg::Rounds - 1)) begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    fill_reg <= '0;
                    if (!finishing_reg) begin
                        state_reg <= S_IDLE;
                    end else if (!pad_len_reg) begin
                        pad_len_reg <= 1'b1;
                        state_reg   <= S_PAD;
                    end else begin
                        widx_reg  <= '0;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_ready) begin
                        widx_reg <= widx_reg + 3'd1;
                        if (widx_reg == 3'd4) begin
                            widx_reg      <= '0;
                            fill_reg      <= '0;
                            msg_reg       <= '0;
                            finishing_reg <= 1'b0;
                            for (int i = 0; i < 5; i++) begin
                                h_reg[i] <= sha1_pkg::init_chain(3'(i));
                            end
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `SHA1_ASSERT_IMPL(a_emit_idx, clk, rst_n, out_valid, word_index <= 3'd4)
    `SHA1_ASSERT_NEXT(a_last_idle, clk, rst_n, out_valid && out_ready && last_word, in_ready)
    `SHA1_ASSERT_IMPL(a_excl, clk, rst_n, out_valid, !in_ready)
    `SHA1_ASSERT_NEXT(a_round_cnt, clk, rst_n, state_reg == S_ROUND && cnt_reg == 7'd79,
        state_reg == S_UPDATE)
endmodule
